// ===== hdl/grm_pkg.sv =====
// ----------------------------------------------------------------------------
// grm_pkg
// Shared types and constants for the graph reachability block.
// ----------------------------------------------------------------------------
package grm_pkg;

    // width of a vertex field on the item channel
    localparam int VERTEX_BITS = 6;
    // largest vertex count that the vertex fields can address
    localparam int VERTEX_SPAN = 2 ** VERTEX_BITS;

    typedef logic [1:0] opcode_t;

    localparam opcode_t OP_ADD   = 2'd0;
    localparam opcode_t OP_QUERY = 2'd1;
    localparam opcode_t OP_CLEAR = 2'd2;

    // control to the adjacency store
    typedef struct packed {
        logic rd;
        logic wr;
        logic clr;
    } adj_cmd_t;

endpackage

// ===== hdl/grm_adj.sv =====
// ----------------------------------------------------------------------------
// grm_adj
// Adjacency bit matrix: one row per tail vertex, single read/write port,
// registered read, per-row valid bits so a clear needs no sweep of the rows.
// ----------------------------------------------------------------------------
module grm_adj
    import grm_pkg::*;
#(
    parameter int ROWS = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  adj_cmd_t                 cmd,
    input  logic [$clog2(ROWS)-1:0]  addr,
    input  logic [ROWS-1:0]          wdata,
    output logic [ROWS-1:0]          rdata
);

    logic [ROWS-1:0] mem [ROWS];
    logic [ROWS-1:0] vld_reg;
    logic [ROWS-1:0] vld_next;
    logic [ROWS-1:0] mem_q_reg;
    logic            vld_q_reg;
    logic            vld_q_next;

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[addr] <= wdata;
        end
        if (cmd.rd)
        begin
            mem_q_reg <= mem[addr];
        end
    end

    always_comb
    begin
        vld_next   = vld_reg;
        vld_q_next = vld_q_reg;
        if (cmd.rd)
        begin
            vld_q_next = vld_reg[addr];
        end
        if (cmd.clr)
        begin
            vld_next = '0;
        end
        else if (cmd.wr)
        begin
            vld_next[addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
        end
        else
        begin
            vld_reg   <= vld_next;
            vld_q_reg <= vld_q_next;
        end
    end

    // a row never written since the last clear reads as empty
    assign rdata = vld_q_reg ? mem_q_reg : '0;

endmodule

// ===== hdl/graph_reachability_memo.sv =====
// ----------------------------------------------------------------------------
// graph_reachability_memo
// Directed graph reachability with a memo of start/end answers.
// ----------------------------------------------------------------------------
// One input channel (in_valid/in_stall) carries items: add an edge, query
// reachability, or clear the graph. One output channel (out_valid/out_stall)
// carries one result per query: reachable and from_memo.
// The block handles one item at a time and holds in_stall high meanwhile.
// Clear and unused opcodes leave the block idle; an edge add steps through
// a row read and a row write. A query hit in the memo goes through memo
// read, memo check and the response state before out_valid rises. A walk
// reads one adjacency row per expanded vertex through the single read port
// and waits for the row when nothing else is pending; vertices at or beyond
// the smaller of VERTEX_COUNT and 64 are never addressed.
// An in-range add or a clear empties the memo; a walk result goes back in.
// Reset empties graph and memo at once through per-row valid bits, no sweep.
// A finished result sits in an output register; when out_stall holds it,
// the next query waits before giving its result, other items go ahead.
// ----------------------------------------------------------------------------
module graph_reachability_memo
    import grm_pkg::*;
#(
    parameter int VERTEX_COUNT = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  opcode_t                opcode,
    input  logic [VERTEX_BITS-1:0] source_vertex,
    input  logic [VERTEX_BITS-1:0] target_vertex,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   reachable,
    output logic                   from_memo
);

    localparam int NV = (VERTEX_COUNT < VERTEX_SPAN) ? VERTEX_COUNT : VERTEX_SPAN;
    localparam int VW = $clog2(NV);
    localparam logic [VERTEX_BITS:0] NV_LIMIT = (VERTEX_BITS+1)'(NV);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_WR,
        S_MEMO_RD,
        S_MEMO_CHK,
        S_WALK,
        S_MEMO_WR,
        S_RESP
    } state_t;

    state_t                 state_reg, state_next;
    logic [VERTEX_BITS-1:0] src_reg, src_next;
    logic [VERTEX_BITS-1:0] dst_reg, dst_next;
    logic [NV-1:0]          visited_reg, visited_next;
    logic [NV-1:0]          pending_reg, pending_next;
    logic                   flight_reg, flight_next;
    logic                   found_reg, found_next;
    logic                   res_reach_reg, res_reach_next;
    logic                   res_memo_reg, res_memo_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   reachable_reg, reachable_next;
    logic                   from_memo_reg, from_memo_next;
    logic [NV-1:0]          memo_vld_reg, memo_vld_next;

    logic [2*NV-1:0]        memo_mem [NV];
    logic [2*NV-1:0]        memo_rd_reg;
    logic                   memo_hvld_reg;
    logic                   memo_rd;
    logic                   memo_we;
    logic [2*NV-1:0]        memo_wdata;

    adj_cmd_t               adj_cmd;
    logic [VW-1:0]          adj_addr;
    logic [NV-1:0]          adj_wdata;
    logic [NV-1:0]          adj_rdata;

    logic                   accept;
    logic                   src_ok;
    logic                   dst_ok;
    logic [VW-1:0]          src_idx;
    logic [VW-1:0]          dst_idx;
    logic [NV-1:0]          dst_bit;
    logic [VW-1:0]          pick;
    logic [NV-1:0]          pick_bit;
    logic [NV-1:0]          known_old;
    logic [NV-1:0]          answer_old;
    logic                   out_free;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign src_ok   = ({1'b0, source_vertex} < NV_LIMIT);
    assign dst_ok   = ({1'b0, target_vertex} < NV_LIMIT);
    assign src_idx  = src_reg[VW-1:0];
    assign dst_idx  = dst_reg[VW-1:0];
    assign dst_bit  = NV'(1) << dst_idx;
    assign pick_bit = NV'(1) << pick;
    assign out_free = !out_valid_reg || !out_stall;

    // lowest pending vertex is expanded next
    always_comb
    begin
        pick = '0;
        for (int i = NV - 1; i >= 0; i--)
        begin
            if (pending_reg[i])
            begin
                pick = VW'(i);
            end
        end
    end

    // memo entry read before the walk, still held when the answer goes back
    assign known_old  = memo_hvld_reg ? memo_rd_reg[NV-1:0] : '0;
    assign answer_old = memo_rd_reg[2*NV-1:NV];

    assign memo_rd    = (state_reg == S_MEMO_RD);
    assign memo_we    = (state_reg == S_MEMO_WR);
    assign memo_wdata = {(found_reg ? (answer_old | dst_bit) : (answer_old & ~dst_bit)),
                         (known_old | dst_bit)};

    always_ff @(posedge clk)
    begin
        if (memo_we)
        begin
            memo_mem[src_idx] <= memo_wdata;
        end
        if (memo_rd)
        begin
            memo_rd_reg <= memo_mem[src_idx];
        end
    end

    always_comb
    begin
        adj_cmd.rd  = 1'b0;
        adj_cmd.wr  = 1'b0;
        adj_cmd.clr = accept && (opcode == OP_CLEAR);
        adj_addr    = (state_reg == S_WALK) ? pick : src_idx;
        adj_wdata   = adj_rdata | dst_bit;
        if (state_reg == S_ADD_RD)
        begin
            adj_cmd.rd = 1'b1;
        end
        if (state_reg == S_ADD_WR)
        begin
            adj_cmd.wr = 1'b1;
        end
        if ((state_reg == S_WALK) && !visited_reg[dst_idx] && (pending_reg != '0))
        begin
            adj_cmd.rd = 1'b1;
        end
    end

    grm_adj #(
        .ROWS (NV)
    ) u_adj (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (adj_cmd),
        .addr  (adj_addr),
        .wdata (adj_wdata),
        .rdata (adj_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        visited_next   = visited_reg;
        pending_next   = pending_reg;
        flight_next    = flight_reg;
        found_next     = found_reg;
        res_reach_next = res_reach_reg;
        res_memo_next  = res_memo_reg;
        memo_vld_next  = memo_vld_reg;
        out_valid_next = out_valid_reg && out_stall;
        reachable_next = reachable_reg;
        from_memo_next = from_memo_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    src_next = source_vertex;
                    dst_next = target_vertex;
                    unique case (opcode)
                        OP_ADD:
                        begin
                            if (src_ok && dst_ok)
                            begin
                                state_next = S_ADD_RD;
                            end
                        end
                        OP_QUERY:
                        begin
                            if (src_ok && dst_ok)
                            begin
                                state_next = S_MEMO_RD;
                            end
                            else
                            begin
                                res_reach_next = 1'b0;
                                res_memo_next  = 1'b0;
                                state_next     = S_RESP;
                            end
                        end
                        OP_CLEAR:
                        begin
                            memo_vld_next = '0;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD_RD:
            begin
                state_next = S_ADD_WR;
            end
            S_ADD_WR:
            begin
                memo_vld_next = '0;
                state_next    = S_IDLE;
            end
            S_MEMO_RD:
            begin
                state_next = S_MEMO_CHK;
            end
            S_MEMO_CHK:
            begin
                if (known_old[dst_idx])
                begin
                    res_reach_next = answer_old[dst_idx];
                    res_memo_next  = 1'b1;
                    state_next     = S_RESP;
                end
                else
                begin
                    visited_next = NV'(1) << src_idx;
                    pending_next = NV'(1) << src_idx;
                    flight_next  = 1'b0;
                    state_next   = S_WALK;
                end
            end
            S_WALK:
            begin
                if (visited_reg[dst_idx])
                begin
                    found_next = 1'b1;
                    state_next = S_MEMO_WR;
                end
                else if ((pending_reg == '0) && !flight_reg)
                begin
                    found_next = 1'b0;
                    state_next = S_MEMO_WR;
                end
                else
                begin
                    // row of the vertex picked last cycle arrives now
                    if (flight_reg)
                    begin
                        pending_next = pending_reg | (adj_rdata & ~visited_reg);
                        visited_next = visited_reg | adj_rdata;
                    end
                    if (pending_reg != '0)
                    begin
                        pending_next = pending_next & ~pick_bit;
                        flight_next  = 1'b1;
                    end
                    else
                    begin
                        flight_next = 1'b0;
                    end
                end
            end
            S_MEMO_WR:
            begin
                memo_vld_next[src_idx] = 1'b1;
                res_reach_next         = found_reg;
                res_memo_next          = 1'b0;
                state_next             = S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    reachable_next = res_reach_reg;
                    from_memo_next = res_memo_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            src_reg       <= '0;
            dst_reg       <= '0;
            visited_reg   <= '0;
            pending_reg   <= '0;
            flight_reg    <= 1'b0;
            found_reg     <= 1'b0;
            res_reach_reg <= 1'b0;
            res_memo_reg  <= 1'b0;
            memo_vld_reg  <= '0;
            memo_hvld_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            reachable_reg <= 1'b0;
            from_memo_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            src_reg       <= src_next;
            dst_reg       <= dst_next;
            visited_reg   <= visited_next;
            pending_reg   <= pending_next;
            flight_reg    <= flight_next;
            found_reg     <= found_next;
            res_reach_reg <= res_reach_next;
            res_memo_reg  <= res_memo_next;
            memo_vld_reg  <= memo_vld_next;
            if (memo_rd)
            begin
                memo_hvld_reg <= memo_vld_reg[src_idx];
            end
            out_valid_reg <= out_valid_next;
            reachable_reg <= reachable_next;
            from_memo_reg <= from_memo_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign reachable = reachable_reg;
    assign from_memo = from_memo_reg;

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the graph reachability block with answer memo.
// ----------------------------------------------------------------------------
// A directed table covers the empty graph, start equals end, self loops,
// duplicate edges, clears, the unused opcode and memo hits. A random part
// then builds small graphs inside vertex windows and long chains, and mixes
// repeated queries (memo hits) with fresh ones, edits and noise. Every query
// is predicted by a breadth-first walk over a local copy of the graph and
// memo, and each result is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import grm_pkg::*;

    localparam int GRAPH_SIZE     = 64;
    localparam int RANDOM_ITEMS   = 880;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 100;
    localparam int RECENT_DEPTH   = 8;
    localparam int DIR_ROWS       = 25;

    localparam opcode_t OP_UNUSED = 2'd3;

    typedef logic [VERTEX_BITS-1:0] vertex_t;

    typedef struct packed {
        opcode_t op;
        vertex_t src;
        vertex_t dst;
        logic    typed;
        logic    reach;
        logic    memo;
    } step_row_t;

    typedef struct packed {
        logic reach;
        logic memo;
    } answer_t;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    in_valid;
    logic    in_stall;
    opcode_t opcode;
    vertex_t source_vertex;
    vertex_t target_vertex;
    logic    out_valid;
    logic    out_stall;
    logic    reachable;
    logic    from_memo;

    // local copy of the graph and the memo
    logic [GRAPH_SIZE-1:0] graph_rows  [GRAPH_SIZE];
    logic [GRAPH_SIZE-1:0] memo_known  [GRAPH_SIZE];
    logic [GRAPH_SIZE-1:0] memo_answer [GRAPH_SIZE];

    answer_t expected_answers [$];
    int      errors     = 0;
    int      items_sent = 0;
    bit      in_calm    = 1'b0;

    // expected result typed in only where it follows at a glance
    step_row_t dir_rows [DIR_ROWS] = '{
        '{OP_QUERY,  6'd0,  6'd0,  1'b1, 1'b1, 1'b0},
        '{OP_QUERY,  6'd0,  6'd0,  1'b1, 1'b1, 1'b1},
        '{OP_QUERY,  6'd63, 6'd0,  1'b1, 1'b0, 1'b0},
        '{OP_QUERY,  6'd63, 6'd0,  1'b1, 1'b0, 1'b1},
        '{OP_ADD,    6'd0,  6'd63, 1'b0, 1'b0, 1'b0},
        '{OP_QUERY,  6'd0,  6'd63, 1'b1, 1'b1, 1'b0},
        '{OP_QUERY,  6'd0,  6'd63, 1'b1, 1'b1, 1'b1},
        '{OP_ADD,    6'd63, 6'd63, 1'b0, 1'b0, 1'b0},
        '{OP_QUERY,  6'd63, 6'd63, 1'b1, 1'b1, 1'b0},
        '{OP_ADD,    6'd0,  6'd63, 1'b0, 1'b0, 1'b0},
        '{OP_QUERY,  6'd0,  6'd63, 1'b1, 1'b1, 1'b0},
        '{OP_ADD,    6'd63, 6'd0,  1'b0, 1'b0, 1'b0},
        '{OP_QUERY,  6'd63, 6'd0,  1'b1, 1'b1, 1'b0},
        '{OP_UNUSED, 6'd63, 6'd63, 1'b0, 1'b0, 1'b0},
        '{OP_QUERY,  6'd63, 6'd0,  1'b1, 1'b1, 1'b1},
        '{OP_CLEAR,  6'd63, 6'd63, 1'b0, 1'b0, 1'b0},
        '{OP_QUERY,  6'd0,  6'd63, 1'b1, 1'b0, 1'b0},
        '{OP_QUERY,  6'd63, 6'd0,  1'b1, 1'b0, 1'b0},
        '{OP_ADD,    6'd1,  6'd2,  1'b0, 1'b0, 1'b0},
        '{OP_ADD,    6'd2,  6'd3,  1'b0, 1'b0, 1'b0},
        '{OP_QUERY,  6'd1,  6'd3,  1'b0, 1'b0, 1'b0},
        '{OP_QUERY,  6'd3,  6'd1,  1'b0, 1'b0, 1'b0},
        '{OP_QUERY,  6'd1,  6'd3,  1'b0, 1'b0, 1'b0},
        '{OP_QUERY,  6'd42, 6'd21, 1'b0, 1'b0, 1'b0},
        '{OP_QUERY,  6'd21, 6'd42, 1'b0, 1'b0, 1'b0}
    };

    graph_reachability_memo #(
        .VERTEX_COUNT (GRAPH_SIZE)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .source_vertex (source_vertex),
        .target_vertex (target_vertex),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .reachable     (reachable),
        .from_memo     (from_memo)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic void wipe_memo();
        for (int v = 0; v < GRAPH_SIZE; v++)
            memo_known[v] = '0;
    endfunction

    // frontier-by-frontier walk, same reach set as a queue walk
    function automatic logic walk_reaches(vertex_t start, vertex_t goal);
        logic [GRAPH_SIZE-1:0] seen;
        logic [GRAPH_SIZE-1:0] frontier;
        logic [GRAPH_SIZE-1:0] grown;
        seen        = '0;
        seen[start] = 1'b1;
        frontier    = seen;
        while (frontier != '0)
        begin
            grown = '0;
            for (int v = 0; v < GRAPH_SIZE; v++)
                if (frontier[v])
                    grown |= graph_rows[v];
            frontier = grown & ~seen;
            seen     = seen | grown;
        end
        return seen[goal];
    endfunction

    // updates the local graph and memo; returns 1 when a result is due
    function automatic logic predict_item(opcode_t op, vertex_t s, vertex_t t,
                                          output answer_t ans);
        logic hit;
        ans = '0;
        case (op)
            OP_ADD:
            begin
                if (s < GRAPH_SIZE && t < GRAPH_SIZE)
                begin
                    graph_rows[s][t] = 1'b1;
                    wipe_memo();
                end
                return 1'b0;
            end
            OP_CLEAR:
            begin
                for (int v = 0; v < GRAPH_SIZE; v++)
                    graph_rows[v] = '0;
                wipe_memo();
                return 1'b0;
            end
            OP_QUERY:
            begin
                if (s >= GRAPH_SIZE || t >= GRAPH_SIZE)
                    return 1'b1;
                if (memo_known[s][t])
                begin
                    ans.reach = memo_answer[s][t];
                    ans.memo  = 1'b1;
                    return 1'b1;
                end
                hit               = walk_reaches(s, t);
                memo_known[s][t]  = 1'b1;
                memo_answer[s][t] = hit;
                ans.reach         = hit;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic send_item(input step_row_t row);
        int      gap;
        answer_t ans;
        logic    has_ans;
        gap = in_calm ? 0 : pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        opcode        <= row.op;
        source_vertex <= row.src;
        target_vertex <= row.dst;
        do
            @(posedge clk);
        while (in_stall);
        has_ans = predict_item(row.op, row.src, row.dst, ans);
        if (has_ans)
        begin
            if (row.typed)
                ans = {row.reach, row.memo};
            expected_answers.push_back(ans);
        end
        if (row.op != OP_UNUSED)
            items_sent++;
    endtask

    task automatic send_op(input opcode_t op, input vertex_t s, input vertex_t t);
        send_item('{op, s, t, 1'b0, 1'b0, 1'b0});
    endtask

    // sender holds off until every pending result has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_answers.size() != 0)
            @(posedge clk);
    endtask

    // receiver side stalls
    initial
    begin
        int stall_left;
        int calm_left;
        stall_left = 0;
        calm_left  = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (calm_left != 0)
                calm_left--;
            else if ($urandom_range(0, 199) == 0)
                calm_left = $urandom_range(50, 300);
            if (stall_left != 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (calm_left == 0 && $urandom_range(0, 2) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_answers.size() == 0)
            begin
                $display("%0t: result with no query waiting: reachable %0b from_memo %0b",
                         $time, reachable, from_memo);
                errors++;
            end
            else
            begin
                want = expected_answers.pop_front();
                if (reachable !== want.reach)
                begin
                    $display("%0t: reachable mismatch: expected %0b, actual %0b",
                             $time, want.reach, reachable);
                    errors++;
                end
                if (from_memo !== want.memo)
                begin
                    $display("%0t: from_memo mismatch: expected %0b, actual %0b",
                             $time, want.memo, from_memo);
                    errors++;
                end
            end
        end
    end

    // no handshake on either side for too long
    always @(posedge clk)
    begin
        int idle_cycles;
        if (!rst_n)
            idle_cycles = 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, idle_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int        kind;
        int        span;
        int        base;
        int        stride;
        int        chain_len;
        int        pick;
        vertex_t   s;
        vertex_t   t;
        vertex_t   head;
        vertex_t   tail;
        logic [11:0] recent_pairs [$];

        for (int v = 0; v < GRAPH_SIZE; v++)
        begin
            graph_rows[v]  = '0;
            memo_known[v]  = '0;
            memo_answer[v] = '0;
        end
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        opcode        = OP_ADD;
        source_vertex = '0;
        target_vertex = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_item(dir_rows[i]);
        drain();

        while (items_sent < DIR_ROWS + RANDOM_ITEMS)
        begin
            in_calm = ($urandom_range(0, 4) == 0);
            kind    = $urandom_range(0, 9);
            if (kind == 9 || $urandom_range(0, 7) == 0)
                drain();
            if (kind == 7)
            begin
                // long chain through distinct vertices, deep walks
                stride    = 2 * $urandom_range(0, 31) + 1;
                base      = $urandom_range(0, GRAPH_SIZE - 1);
                chain_len = $urandom_range(8, GRAPH_SIZE - 1);
                send_op(OP_CLEAR, vertex_t'($urandom), vertex_t'($urandom));
                for (int i = 0; i < chain_len; i++)
                    send_op(OP_ADD, vertex_t'(base + i * stride),
                            vertex_t'(base + (i + 1) * stride));
                head = vertex_t'(base);
                tail = vertex_t'(base + chain_len * stride);
                send_op(OP_QUERY, head, tail);
                send_op(OP_QUERY, tail, head);
                send_op(OP_QUERY, head, tail);
                send_op(OP_QUERY, vertex_t'(base + $urandom_range(0, chain_len) * stride),
                        tail);
            end
            else if (kind == 8)
            begin
                // noise over the full field ranges, unused opcode included
                for (int i = 0; i < 10; i++)
                    send_op(opcode_t'($urandom), vertex_t'($urandom), vertex_t'($urandom));
            end
            else
            begin
                // small graph inside a vertex window, then queries with repeats
                span = $urandom_range(3, 16);
                base = $urandom_range(0, GRAPH_SIZE - span);
                if ($urandom_range(0, 1) == 0)
                    send_op(OP_CLEAR, vertex_t'($urandom), vertex_t'($urandom));
                repeat ($urandom_range(1, 2 * span))
                begin
                    s = vertex_t'(base + $urandom_range(0, span - 1));
                    t = vertex_t'(base + $urandom_range(0, span - 1));
                    if ($urandom_range(0, 9) == 0)
                        t = vertex_t'($urandom);
                    if ($urandom_range(0, 19) == 0)
                        send_op(OP_UNUSED, vertex_t'($urandom), vertex_t'($urandom));
                    send_op(OP_ADD, s, t);
                end
                repeat ($urandom_range(3, 12))
                begin
                    pick = $urandom_range(0, 99);
                    if (recent_pairs.size() != 0 && pick < 40)
                        {s, t} = recent_pairs[$urandom_range(0, recent_pairs.size() - 1)];
                    else if (pick < 48)
                    begin
                        s = vertex_t'($urandom);
                        t = vertex_t'($urandom);
                    end
                    else
                    begin
                        s = vertex_t'(base + $urandom_range(0, span - 1));
                        t = vertex_t'(base + $urandom_range(0, span - 1));
                    end
                    // an edit now and then drops the memo mid-burst
                    if ($urandom_range(0, 11) == 0)
                        send_op(OP_ADD, vertex_t'(base + $urandom_range(0, span - 1)),
                                vertex_t'(base + $urandom_range(0, span - 1)));
                    send_op(OP_QUERY, s, t);
                    recent_pairs.push_back({s, t});
                    if (recent_pairs.size() > RECENT_DEPTH)
                        void'(recent_pairs.pop_front());
                end
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && expected_answers.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
